@@ src/solc_pkg.sv @@
// ----------------------------------------------------------------------------
// solc_pkg
// Shared types and constants for the self-organizing list search block.
// ----------------------------------------------------------------------------
package solc_pkg;

  localparam int KEY_W     = 32;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 2;
  localparam int POS_OUT_W = 4;
  localparam int CNT_OUT_W = 5;
  localparam int POL_W     = 2;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 1;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_SEARCH = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_MISS  = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_BADOP = 2'd3
  } status_t;

  typedef enum logic [POL_W-1:0] {
    POL_PLAIN     = 2'd0,
    POL_MTF       = 2'd1,
    POL_TRANSPOSE = 2'd2
  } policy_t;

  localparam logic [APB_AW-1:0] REG_POLICY = 1'b0;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_SHIFT = 2'd2
  } cell_mode_t;

  typedef struct packed {
    logic       cmp;
    logic       in_list;
    cell_mode_t mode;
  } cell_ctrl_t;

endpackage

@@ src/solc_in_if.sv @@
// ----------------------------------------------------------------------------
// solc_in_if
// Operation channel: one beat carries an operation code and a key.
// ----------------------------------------------------------------------------
interface solc_in_if;
  logic                                valid;
  logic                                ready;
  logic        [solc_pkg::OP_W-1:0]    operation;
  logic signed [solc_pkg::KEY_W-1:0]   key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);
endinterface

@@ src/solc_out_if.sv @@
// ----------------------------------------------------------------------------
// solc_out_if
// Result channel: one beat per operation with status, positions and count.
// ----------------------------------------------------------------------------
interface solc_out_if;
  logic                              valid;
  logic                              ready;
  logic [solc_pkg::STAT_W-1:0]       status;
  logic [solc_pkg::POS_OUT_W-1:0]    found_position;
  logic [solc_pkg::POS_OUT_W-1:0]    new_position;
  logic [solc_pkg::CNT_OUT_W-1:0]    entry_count;

  modport source (output valid, output status, output found_position,
                  output new_position, output entry_count, input ready);
  modport sink   (input valid, input status, input found_position,
                  input new_position, input entry_count, output ready);
endinterface

@@ src/self_organizing_list_search.sv @@
// ----------------------------------------------------------------------------
// self_organizing_list_search
// Bounded self-organizing key list built from a row of compare-and-shift
// cells, with plain, move-to-front and transpose policies.
// ----------------------------------------------------------------------------
// Every operation passes through the row in order: the cycle that ends in the
// accept edge, a compare state in which all cells compare their key in
// parallel, a resolve state that finds the first hit across the row, and an
// update state that moves entries between neighboring cells and registers the
// result beat; the update state waits while a held result is not taken. The
// next operation is taken once the row is back in idle, so the row works on
// one operation at a time; the result register lets a new operation start
// while a result waits. Entries hold no reset value; only slots below the
// entry count are ever compared.
// ----------------------------------------------------------------------------
module self_organizing_list_search #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  solc_in_if.sink                           in_ch,
  solc_out_if.source                        out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [solc_pkg::APB_AW-1:0]       paddr,
  input  logic [solc_pkg::APB_DW-1:0]       pwdata,
  output logic [solc_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);
  import solc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_RES  = 4'b0100,
    S_UPD  = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  op_t              op_r;
  logic [KEY_W-1:0] key_r;
  logic [POL_W-1:0] policy_r;
  logic [CW-1:0]    count_r, count_nxt;

  logic             found_r, found_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [DEPTH-1:0] first_oh_r, first_oh_nxt;
  logic [DEPTH-1:0] none_before_r, none_before_nxt;

  logic [DEPTH-1:0] hit;
  logic [KEY_W-1:0] entry [DEPTH];
  cell_ctrl_t       ctrl [DEPTH];

  logic             out_valid_r;
  logic [STAT_W-1:0]    out_status_r;
  logic [POS_OUT_W-1:0] out_fpos_r;
  logic [POS_OUT_W-1:0] out_npos_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;

  logic             adv;
  logic             full;
  status_t          stat_nxt;
  logic [PW-1:0]    fpos_nxt, npos_nxt;

  assign full = (count_r == CW'(DEPTH));
  assign adv  = (state_r == S_UPD) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = (state_r == S_IDLE);

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_POLICY) ? APB_DW'(policy_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_PLAIN;
    end else if (psel && penable && pwrite && (paddr == REG_POLICY)) begin
      policy_r <= pwdata[POL_W-1:0];
    end
  end

  // Cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_comb begin
      ctrl[i].cmp     = (state_r == S_CMP);
      ctrl[i].in_list = (CW'(i) < count_r);
      ctrl[i].mode    = CELL_HOLD;
      if (adv) begin
        unique case (op_r)
          OP_APPEND: begin
            if (!full && (count_r == CW'(i))) ctrl[i].mode = CELL_LOAD;
          end
          OP_SEARCH: begin
            if (found_r) begin
              if (policy_r == POL_MTF) begin
                if (i == 0) ctrl[i].mode = CELL_LOAD;
                else if (none_before_r[i]) ctrl[i].mode = CELL_SHIFT;
              end else if (policy_r == POL_TRANSPOSE) begin
                if ((i > 0) && first_oh_r[i]) ctrl[i].mode = CELL_SHIFT;
                else if ((i < DEPTH - 1) && first_oh_r[(i + 1) % DEPTH])
                  ctrl[i].mode = CELL_LOAD;
              end
            end
          end
          default: ctrl[i].mode = CELL_HOLD;
        endcase
      end
    end

    solc_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[i]),
      .key        (key_r),
      .prev_entry ((i == 0) ? key_r : entry[(i + DEPTH - 1) % DEPTH]),
      .entry      (entry[i]),
      .hit        (hit[i])
    );
  end

  // First-hit resolution
  always_comb begin
    logic acc;
    acc             = 1'b0;
    pos_nxt         = '0;
    first_oh_nxt    = '0;
    none_before_nxt = '0;
    for (int i = 0; i < DEPTH; i++) begin
      none_before_nxt[i] = !acc;
      first_oh_nxt[i]    = hit[i] && !acc;
      if (hit[i] && !acc) pos_nxt = pos_nxt | PW'(i);
      acc = acc | hit[i];
    end
    found_nxt = acc;
  end

  // Result and count
  always_comb begin
    count_nxt = count_r;
    stat_nxt  = STAT_OK;
    fpos_nxt  = '0;
    npos_nxt  = '0;
    unique case (op_r)
      OP_APPEND: begin
        if (full) begin
          stat_nxt = STAT_FULL;
        end else begin
          fpos_nxt  = count_r[PW-1:0];
          npos_nxt  = count_r[PW-1:0];
          count_nxt = count_r + CW'(1);
        end
      end
      OP_SEARCH: begin
        if (!found_r) begin
          stat_nxt = STAT_MISS;
        end else begin
          fpos_nxt = pos_r;
          npos_nxt = pos_r;
          if (policy_r == POL_MTF) npos_nxt = '0;
          else if ((policy_r == POL_TRANSPOSE) && (pos_r != '0))
            npos_nxt = pos_r - PW'(1);
        end
      end
      OP_CLEAR: count_nxt = '0;
      default:  stat_nxt  = STAT_BADOP;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_RES;
      S_RES:   state_nxt = S_UPD;
      S_UPD:   if (adv) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (adv) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r  <= op_t'(in_ch.operation);
      key_r <= in_ch.key;
    end
    if (state_r == S_RES) begin
      found_r       <= found_nxt;
      pos_r         <= pos_nxt;
      first_oh_r    <= first_oh_nxt;
      none_before_r <= none_before_nxt;
    end
    if (adv) begin
      out_status_r <= stat_nxt;
      out_fpos_r   <= POS_OUT_W'(fpos_nxt);
      out_npos_r   <= POS_OUT_W'(npos_nxt);
      out_cnt_r    <= CNT_OUT_W'(count_nxt);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.found_position = out_fpos_r;
  assign out_ch.new_position   = out_npos_r;
  assign out_ch.entry_count    = out_cnt_r;
endmodule

@@ src/solc_cell.sv @@
// ----------------------------------------------------------------------------
// solc_cell
// One list slot: holds a key, compares it to the search key, and loads
// either the key or its predecessor's entry.
// ----------------------------------------------------------------------------
module solc_cell (
  input  logic                               clk,
  input  solc_pkg::cell_ctrl_t               ctrl,
  input  logic [solc_pkg::KEY_W-1:0]         key,
  input  logic [solc_pkg::KEY_W-1:0]         prev_entry,
  output logic [solc_pkg::KEY_W-1:0]         entry,
  output logic                               hit
);
  import solc_pkg::*;

  logic [KEY_W-1:0] entry_r;
  logic [KEY_W-1:0] entry_nxt;
  logic             hit_r;

  always_comb begin
    case (ctrl.mode)
      CELL_LOAD:  entry_nxt = key;
      CELL_SHIFT: entry_nxt = prev_entry;
      default:    entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctrl.cmp) begin
      hit_r <= ctrl.in_list && (entry_r == key);
    end
  end

  assign entry = entry_r;
  assign hit   = hit_r;
endmodule

@@ src/solc_checker.sv @@
// ----------------------------------------------------------------------------
// solc_checker
// Port-level checks for the self-organizing list search block.
// ----------------------------------------------------------------------------
module solc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [solc_pkg::STAT_W-1:0]         out_status,
  input logic [solc_pkg::POS_OUT_W-1:0]      out_found_position,
  input logic [solc_pkg::POS_OUT_W-1:0]      out_new_position,
  input logic [solc_pkg::CNT_OUT_W-1:0]      out_entry_count
);
  import solc_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_found_position) && $stable(out_new_position) &&
      $stable(out_entry_count))
    else $error("result beat changed while stalled");

  // one operation in flight
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("operation accepted while busy");

  // miss, full and bad operation carry zero positions
  a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_MISS || out_status == STAT_FULL ||
      out_status == STAT_BADOP) |-> out_found_position == '0 &&
      out_new_position == '0)
    else $error("nonzero position on unsuccessful beat");

  // an idle result channel comes alive only in response to an accepted beat
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 4))
    else $error("result beat without a matching operation beat");

endmodule

bind self_organizing_list_search solc_checker u_solc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_status         (out_ch.status),
  .out_found_position (out_ch.found_position),
  .out_new_position   (out_ch.new_position),
  .out_entry_count    (out_ch.entry_count)
);
